>>> rtl/apq_pkg.sv
// Package for the array priority queue: sizes, codes, word types and sequencer states.
`timescale 1ns / 1ps

package apq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PRI_W = 16;
  localparam int PAY_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    opcode;
    logic signed [PRI_W-1:0] priority_req;
    logic signed [PAY_W-1:0] payload;
  } req_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [PRI_W-1:0] out_priority;
    logic signed [PAY_W-1:0] out_payload;
  } rsp_word_t;

  typedef struct packed {
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [PRI_W-1:0] wpri;
    logic signed [PAY_W-1:0] wpay;
    logic [IDX_W-1:0]        raddr;
  } store_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_MIN,
    S_FIND,
    S_DONE
  } seq_state_t;

  // One slot down the ring, wrapping from slot zero to the top slot.
  function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] s);
    if (s == '0) begin
      return IDX_W'(DEPTH - 1);
    end
    return s - IDX_W'(1);
  endfunction

endpackage

>>> rtl/array_priority_queue.sv
// Top level of the array priority queue: sequencer, slot storage and the result register.
`timescale 1ns / 1ps

// The queue holds up to DEPTH entries, each a signed priority and a payload.
// Request words enter on req/req_valid/req_stall: an insert or a remove of
// the entry with the smallest priority. Every request yields one response
// word on rsp/rsp_valid/rsp_stall with a status (done, full, empty) and, for
// a remove, the priority and payload taken out.
// One request is worked at a time; req_stall is high from acceptance until
// its response is loaded into the output register. An insert walks the
// slots one per cycle from the cursor down to the first free one. A remove
// makes one pass over all slots through the single read port to find the
// minimum, then a second pass from the cursor to find the first slot
// holding it. A full insert or an empty remove answers without a scan.
// Reset empties the queue at once and sets the cursor to the top slot.
// While the receiver stalls, the response word holds in the output register;
// the next request is still accepted and worked, and it waits for the
// register to free before it completes.

module array_priority_queue
  import apq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  store_req_t              store;
  logic signed [PRI_W-1:0] rd_pri;
  logic signed [PAY_W-1:0] rd_pay;
  logic                    res_valid;
  rsp_word_t               res;
  logic                    res_take;

  assign res_take = !rsp_valid || !rsp_stall;

  apq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .store     (store),
    .rd_pri    (rd_pri),
    .rd_pay    (rd_pay),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  apq_store u_store (
    .clk    (clk),
    .req    (store),
    .rd_pri (rd_pri),
    .rd_pay (rd_pay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      rsp <= res;
    end
  end

endmodule

>>> rtl/apq_store.sv
// Slot storage for priority and payload, one write and one registered read per cycle.
`timescale 1ns / 1ps

module apq_store
  import apq_pkg::*;
(
  input  logic                    clk,
  input  store_req_t              req,
  output logic signed [PRI_W-1:0] rd_pri,
  output logic signed [PAY_W-1:0] rd_pay
);

  logic signed [PRI_W-1:0] pri_mem [DEPTH];
  logic signed [PAY_W-1:0] pay_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      pri_mem[req.waddr] <= req.wpri;
      pay_mem[req.waddr] <= req.wpay;
    end
    rd_pri <= pri_mem[req.raddr];
    rd_pay <= pay_mem[req.raddr];
  end

endmodule

>>> rtl/apq_seq.sv
// Sequencer with the shared priority comparator: slot scans for insert, minimum and removal.
`timescale 1ns / 1ps

module apq_seq
  import apq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  req_word_t               req,
  output logic                    req_stall,
  output store_req_t              store,
  input  logic signed [PRI_W-1:0] rd_pri,
  input  logic signed [PAY_W-1:0] rd_pay,
  output logic                    res_valid,
  output rsp_word_t               res,
  input  logic                    res_take
);

  seq_state_t state, state_next;

  logic [DEPTH-1:0]        used;
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        cursor;
  logic [IDX_W-1:0]        ptr;
  logic                    iss_done;
  logic                    issue_en;
  logic                    chk_valid;
  logic                    chk_used;
  logic                    chk_last;
  logic [IDX_W-1:0]        chk_idx;
  logic signed [PRI_W-1:0] best;
  logic                    found;
  logic signed [PRI_W-1:0] op_pri;
  logic signed [PAY_W-1:0] op_pay;
  logic                    cmp_lt;
  logic                    cmp_eq;
  logic                    hit;

  // The one comparator, used for the minimum pass and for the match pass.
  assign cmp_lt = rd_pri < best;
  assign cmp_eq = rd_pri == best;
  assign hit    = chk_valid && chk_used && cmp_eq;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.opcode == OP_INSERT) begin
            state_next = (count == CNT_W'(DEPTH)) ? S_DONE : S_INS;
          end else begin
            state_next = (count == '0) ? S_DONE : S_MIN;
          end
        end
      end
      S_INS: begin
        if (!used[ptr]) begin
          state_next = S_DONE;
        end
      end
      S_MIN: begin
        if (chk_valid && chk_last) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (hit) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall   = (state != S_IDLE);
    res_valid   = (state == S_DONE);
    issue_en    = ((state == S_MIN) && !iss_done) || (state == S_FIND);
    store.we    = (state == S_INS) && !used[ptr];
    store.waddr = ptr;
    store.wpri  = op_pri;
    store.wpay  = op_pay;
    store.raddr = ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      count     <= '0;
      cursor    <= IDX_W'(DEPTH - 1);
      chk_valid <= 1'b0;
      iss_done  <= 1'b0;
      found     <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= issue_en;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            ptr          <= (req.opcode == OP_INSERT) ? cursor : '0;
            iss_done     <= 1'b0;
            found        <= 1'b0;
            res.status   <= (req.opcode == OP_INSERT) ? ST_FULL : ST_EMPTY;
            res.out_priority <= '0;
            res.out_payload  <= '0;
          end
        end
        S_INS: begin
          if (!used[ptr]) begin
            used[ptr]  <= 1'b1;
            cursor     <= ptr;
            count      <= count + CNT_W'(1);
            res.status <= ST_DONE;
          end else begin
            ptr <= slot_dec(ptr);
          end
        end
        S_MIN: begin
          if (!iss_done) begin
            if (ptr == IDX_W'(DEPTH - 1)) begin
              iss_done <= 1'b1;
            end else begin
              ptr <= ptr + IDX_W'(1);
            end
          end
          if (chk_valid && chk_used && (!found || cmp_lt)) begin
            best  <= rd_pri;
            found <= 1'b1;
          end
          // The match pass starts at the cursor once the minimum is settled.
          if (chk_valid && chk_last) begin
            ptr <= cursor;
          end
        end
        S_FIND: begin
          ptr <= slot_dec(ptr);
          if (hit) begin
            used[chk_idx]    <= 1'b0;
            count            <= count - CNT_W'(1);
            res.status       <= ST_DONE;
            res.out_priority <= rd_pri;
            res.out_payload  <= rd_pay;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Operand capture on acceptance, and the slot tag that travels alongside the registered memory read.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op_pri <= req.priority_req;
      op_pay <= req.payload;
    end
    chk_used <= used[ptr];
    chk_idx  <= ptr;
    chk_last <= (ptr == IDX_W'(DEPTH - 1));
  end

endmodule

>>> dv/array_priority_queue_tb.sv
// Testbench for the array priority queue: directed and random requests checked against a queue model.
`timescale 1ns / 1ps

module array_priority_queue_tb;
  import apq_pkg::*;

  localparam int RANDOM_ITEMS = 630;
  localparam int CALM_ITEMS   = 100;
  localparam int QUIET_LIMIT  = 2000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  array_priority_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the slot array, updated as each request word is accepted.
  logic                    shadow_used [DEPTH];
  logic signed [PRI_W-1:0] shadow_pri  [DEPTH];
  logic signed [PAY_W-1:0] shadow_pay  [DEPTH];
  int                      shadow_count;
  logic [IDX_W-1:0]        shadow_cursor;

  rsp_word_t pending_rsp[$];
  int        error_count = 0;
  bit        req_idle_on = 1'b0;
  bit        rsp_idle_on = 1'b0;
  int        stall_left  = 0;
  int        quiet_cycles = 0;

  function automatic rsp_word_t queue_model_step(input req_word_t w);
    rsp_word_t               r;
    logic [IDX_W-1:0]        s;
    logic signed [PRI_W-1:0] lowest;
    logic                    hit;
    logic                    taken;
    r = '0;
    r.status = ST_DONE;
    s = shadow_cursor;
    hit = 1'b0;
    if (w.opcode == OP_INSERT) begin
      // Walk down the ring from the cursor, cursor slot first.
      for (int k = 0; k < DEPTH; k++) begin
        if (!hit && shadow_count < DEPTH) begin
          if (!shadow_used[s]) begin
            shadow_used[s] = 1'b1;
            shadow_pri[s] = w.priority_req;
            shadow_pay[s] = w.payload;
            shadow_cursor = s;
            shadow_count++;
            hit = 1'b1;
          end else begin
            s = (s == '0) ? IDX_W'(DEPTH - 1) : s - IDX_W'(1);
          end
        end
      end
      if (!hit) r.status = ST_FULL;
    end else begin
      lowest = '0;
      for (int k = 0; k < DEPTH; k++) begin
        if (shadow_used[k] && (!hit || shadow_pri[k] < lowest)) begin
          lowest = shadow_pri[k];
          hit = 1'b1;
        end
      end
      if (!hit) begin
        r.status = ST_EMPTY;
      end else begin
        // Among ties, the first one met going down from the cursor leaves.
        taken = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
          if (!taken) begin
            if (shadow_used[s] && shadow_pri[s] == lowest) begin
              shadow_used[s] = 1'b0;
              shadow_count--;
              r.out_priority = shadow_pri[s];
              r.out_payload = shadow_pay[s];
              taken = 1'b1;
            end else begin
              s = (s == '0) ? IDX_W'(DEPTH - 1) : s - IDX_W'(1);
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic req_word_t make_word(input logic op, input logic signed [PRI_W-1:0] pri,
                                          input logic signed [PAY_W-1:0] pay);
    req_word_t w;
    w.opcode = op;
    w.priority_req = pri;
    w.payload = pay;
    return w;
  endfunction

  // Present one word and hold it until accepted. Valid stays high on return so that
  // back-to-back words need no drop in between.
  task automatic send_word(input req_word_t w);
    if (req_idle_on && $urandom_range(0, 2) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_rsp.push_back(queue_model_step(w));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
      if (rsp_idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response word, expected none, actual %h", $time, rsp);
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, rsp.status);
          error_count++;
        end
        if (rsp.out_priority !== want.out_priority) begin
          $display("%0t: out_priority mismatch, expected %0d, actual %0d",
                   $time, want.out_priority, rsp.out_priority);
          error_count++;
        end
        if (rsp.out_payload !== want.out_payload) begin
          $display("%0t: out_payload mismatch, expected %h, actual %h",
                   $time, want.out_payload, rsp.out_payload);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[array_priority_queue] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_remove_on_empty();
    send_word(make_word(OP_REMOVE, 16'sh1234, 32'h5555_AAAA));
  endtask

  // Fill every slot with extreme and repeated priorities, then try one more insert.
  task automatic test_fill_until_full();
    logic signed [PRI_W-1:0] fill_pri [DEPTH];
    logic signed [PAY_W-1:0] fill_pay;
    fill_pri = '{16'sh8000, 16'sh7FFF, 16'sd3, 16'sd3, 16'sd0, -16'sd1, 16'sd3, 16'sh8000,
                 16'sd100, 16'sd0, -16'sd5, 16'sh7FFF, 16'sd3, -16'sd1, 16'sd7, 16'sd0};
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: fill_pay = 32'h7FFF_FFFF;
        1: fill_pay = 32'h8000_0000;
        2: fill_pay = 32'h0000_0000;
        default: fill_pay = 32'hFFFF_FFF0 | i;
      endcase
      send_word(make_word(OP_INSERT, fill_pri[i], fill_pay ^ (i << 8)));
    end
    send_word(make_word(OP_INSERT, 16'sh8000, 32'h1234_5678));
  endtask

  task automatic test_drain_lowest_first();
    for (int i = 0; i < 6; i++) send_word(make_word(OP_REMOVE, '0, '0));
  endtask

  // Phases lean toward inserts or removes so the queue keeps filling and draining.
  task automatic test_random_traffic();
    int                      insert_pct;
    logic                    op;
    logic signed [PRI_W-1:0] pri;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 25;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
        req_idle_on = ($urandom_range(0, 2) != 0);
        rsp_idle_on = ($urandom_range(0, 2) != 0);
      end
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
      end
      op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
      case ($urandom_range(0, 9))
        0: pri = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
        1, 2: pri = PRI_W'($urandom);
        default: begin
          // A narrow range makes ties common.
          pri = PRI_W'($urandom_range(0, 8));
          pri = pri - 16'sd4;
        end
      endcase
      send_word(make_word(op, pri, $urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_used[i] = 1'b0;
      shadow_pri[i] = '0;
      shadow_pay[i] = '0;
    end
    shadow_count = 0;
    shadow_cursor = IDX_W'(DEPTH - 1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_remove_on_empty();
    test_fill_until_full();
    test_drain_lowest_first();
    test_random_traffic();

    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (2 * DEPTH + 8) @(posedge clk);

    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("[array_priority_queue] OK");
    end else begin
      $display("[array_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
